[rtl/wtc_pkg.sv]
// Shared types and constants of the wall type classifier.
`default_nettype none
package wtc_pkg;

    // Configuration register widths and port format
    localparam int THR_BITS      = 10;
    localparam int WLEN_CFG_BITS = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int GSTATE_BITS   = 4;
    localparam int CLS_BITS      = 2;

    localparam logic [THR_BITS-1:0]      WALL_THRESHOLD_RST  = THR_BITS'(144);
    localparam logic [WLEN_CFG_BITS-1:0] MIN_WALL_LENGTH_RST = WLEN_CFG_BITS'(320);
    localparam logic [THR_BITS-1:0]      SPREAD_LIMIT_RST    = THR_BITS'(32);
    localparam logic [THR_BITS-1:0]      ROUND_THRESHOLD_RST = THR_BITS'(176);

    // Side minimum reset value before masking to the distance width
    localparam int SIDE_MIN_RST = 320;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WALL_THRESHOLD  = 2'd0,
        REG_MIN_WALL_LENGTH = 2'd1,
        REG_SPREAD_LIMIT    = 2'd2,
        REG_ROUND_THRESHOLD = 2'd3
    } cfg_reg_t;

    typedef enum logic [CLS_BITS-1:0] {
        CLS_NONE   = 2'd0,
        CLS_MEAS   = 2'd1,
        CLS_SMOOTH = 2'd2,
        CLS_RIBBED = 2'd3
    } cls_t;

    typedef enum logic [GSTATE_BITS-1:0] {
        G_NONE     = 4'd0,
        G_SMOOTH_L = 4'd1,
        G_SMOOTH_R = 4'd2,
        G_RIBBED_L = 4'd3,
        G_RIBBED_R = 4'd4,
        G_GATE     = 4'd5,
        G_ERROR    = 4'd6,
        G_ROUND_R  = 4'd7,
        G_ROUND_L  = 4'd8
    } gstate_t;

    // What a side lane hands to the merge stage
    typedef struct packed {
        cls_t cls;
        logic near_round;
    } side_stat_t;

    typedef struct packed {
        gstate_t global_state;
        cls_t    right_side_state;
        cls_t    left_side_state;
        logic    state_changed;
    } result_t;

endpackage
`default_nettype wire

[rtl/wtc_if.sv]
// Handshake channels of the wall type classifier: sample input and result output.
`default_nettype none
interface wtc_in_if #(
    parameter int DIST_BITS = 10,
    parameter int POS_BITS  = 32
);
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [DIST_BITS-1:0]       right_distance;
    logic [DIST_BITS-1:0]       left_distance;
    logic signed [POS_BITS-1:0] odometer_position;
    logic                       dashed_line;
    logic [3:0]                 forced_state;

    modport source (
        output valid, command, right_distance, left_distance,
               odometer_position, dashed_line, forced_state,
        input  ready
    );
    modport sink (
        input  valid, command, right_distance, left_distance,
               odometer_position, dashed_line, forced_state,
        output ready
    );
endinterface

interface wtc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] global_state;
    logic [1:0] right_side_state;
    logic [1:0] left_side_state;
    logic       state_changed;

    modport source (
        output valid, global_state, right_side_state, left_side_state, state_changed,
        input  ready
    );
    modport sink (
        input  valid, global_state, right_side_state, left_side_state, state_changed,
        output ready
    );
endinterface
`default_nettype wire

[rtl/wtc_side.sv]
// One side lane: wall detection, min/max tracking, length and classification.
`default_nettype none
module wtc_side #(
    parameter int DIST_BITS = 10,
    parameter int POS_BITS  = 32,
    parameter int LEN_BITS  = 24
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic [DIST_BITS-1:0]                distance,
    input  wire logic [POS_BITS-1:0]                 position,
    input  wire logic [wtc_pkg::THR_BITS-1:0]        wall_threshold,
    input  wire logic [wtc_pkg::WLEN_CFG_BITS-1:0]   min_wall_length,
    input  wire logic [wtc_pkg::THR_BITS-1:0]        spread_limit,
    input  wire logic [wtc_pkg::THR_BITS-1:0]        roundabout_threshold,
    output wtc_pkg::side_stat_t                      stat
);
    import wtc_pkg::*;

    localparam int CMP_BITS = (DIST_BITS > THR_BITS) ? DIST_BITS : THR_BITS;
    localparam int SUM_BITS = ((LEN_BITS > POS_BITS) ? LEN_BITS : POS_BITS) + 1;
    localparam int LC_BITS  = (LEN_BITS > WLEN_CFG_BITS + 1) ? LEN_BITS : WLEN_CFG_BITS + 1;
    localparam logic signed [LEN_BITS-1:0] LEN_MAX = {1'b0, {(LEN_BITS-1){1'b1}}};
    localparam logic signed [LEN_BITS-1:0] LEN_MIN = {1'b1, {(LEN_BITS-1){1'b0}}};

    cls_t                       cls_reg, cls_next;
    logic [DIST_BITS-1:0]       min_reg, min_next;
    logic [DIST_BITS-1:0]       max_reg, max_next;
    logic [POS_BITS-1:0]        last_pos_reg, last_pos_next;
    logic signed [LEN_BITS-1:0] length_reg, length_next;

    logic [CMP_BITS-1:0]        d_ext;
    logic [CMP_BITS-1:0]        thr_ext;
    logic [CMP_BITS-1:0]        spread_ext;
    logic [CMP_BITS-1:0]        round_ext;
    logic [DIST_BITS-1:0]       min_upd;
    logic [DIST_BITS-1:0]       max_upd;
    logic [DIST_BITS-1:0]       spread;
    logic signed [POS_BITS-1:0] travel;
    logic signed [SUM_BITS-1:0] len_sum;
    logic signed [LEN_BITS-1:0] len_sat;
    logic signed [LC_BITS-1:0]  len_cmp;
    logic signed [LC_BITS-1:0]  wlen_cmp;

    assign d_ext      = CMP_BITS'(distance);
    assign thr_ext    = CMP_BITS'(wall_threshold);
    assign spread_ext = CMP_BITS'(spread_limit);
    assign round_ext  = CMP_BITS'(roundabout_threshold);

    assign min_upd  = (distance < min_reg) ? distance : min_reg;
    assign max_upd  = (distance > max_reg) ? distance : max_reg;
    assign spread   = max_upd - min_upd;

    // Travel per tick is the wrapped position difference read as signed
    assign travel   = signed'(position - last_pos_reg);
    assign len_sum  = SUM_BITS'(length_reg) + SUM_BITS'(travel);
    always_comb
    begin
        if (len_sum > SUM_BITS'(LEN_MAX))
            len_sat = LEN_MAX;
        else if (len_sum < SUM_BITS'(LEN_MIN))
            len_sat = LEN_MIN;
        else
            len_sat = len_sum[LEN_BITS-1:0];
    end
    assign len_cmp  = LC_BITS'(len_sat);
    assign wlen_cmp = signed'(LC_BITS'(min_wall_length));

    always_comb
    begin
        cls_next      = cls_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        last_pos_next = last_pos_reg;
        length_next   = length_reg;
        if (en)
        begin
            if (d_ext > thr_ext)
                cls_next = CLS_NONE;
            else if (d_ext < thr_ext)
            begin
                case (cls_reg)
                    CLS_NONE:
                    begin
                        min_next      = distance;
                        max_next      = distance;
                        last_pos_next = position;
                        length_next   = '0;
                        cls_next      = CLS_MEAS;
                    end
                    CLS_MEAS:
                    begin
                        min_next      = min_upd;
                        max_next      = max_upd;
                        last_pos_next = position;
                        length_next   = len_sat;
                        if (len_cmp > wlen_cmp)
                            cls_next = (CMP_BITS'(spread) < spread_ext) ? CLS_SMOOTH
                                                                        : CLS_RIBBED;
                    end
                    default:
                    begin
                        // classified wall still near: hold
                    end
                endcase
            end
        end
    end

    assign stat.cls        = cls_next;
    assign stat.near_round = (d_ext < round_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_reg      <= CLS_NONE;
            min_reg      <= DIST_BITS'(SIDE_MIN_RST);
            max_reg      <= '0;
            last_pos_reg <= '0;
            length_reg   <= '0;
        end
        else
        begin
            cls_reg      <= cls_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            last_pos_reg <= last_pos_next;
            length_reg   <= length_next;
        end
    end

endmodule
`default_nettype wire

[rtl/wtc_merge.sv]
// Merge stage: combines the two side classes, the roundabout check and a forced state command into the global state.
`default_nettype none
module wtc_merge (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            en,
    input  wire logic                            command,
    input  wire logic [wtc_pkg::GSTATE_BITS-1:0] forced_state,
    input  wire logic                            dashed_line,
    input  wire wtc_pkg::side_stat_t             right_stat,
    input  wire wtc_pkg::side_stat_t             left_stat,
    output wtc_pkg::gstate_t                     global_state,
    output logic                                 state_changed
);
    import wtc_pkg::*;

    gstate_t overall_reg, overall_next;
    gstate_t comb_state;
    gstate_t g;

    always_comb
    begin
        g = overall_reg;
        case (right_stat.cls)
            CLS_NONE:
            begin
                if (left_stat.cls == CLS_NONE)
                    g = G_NONE;
                else if (left_stat.cls == CLS_SMOOTH && overall_reg != G_GATE)
                    g = G_SMOOTH_L;
                else if (left_stat.cls == CLS_RIBBED)
                    g = G_RIBBED_L;
            end
            CLS_SMOOTH:
            begin
                if (left_stat.cls == CLS_NONE && overall_reg != G_GATE)
                    g = G_SMOOTH_R;
                else if (left_stat.cls == CLS_SMOOTH)
                    g = G_GATE;
                else if (left_stat.cls == CLS_RIBBED)
                    g = G_ERROR;
            end
            CLS_RIBBED:
                g = (left_stat.cls == CLS_NONE) ? G_RIBBED_R : G_ERROR;
            default:
            begin
                // right side still measuring: hold
            end
        endcase

        // roundabout check, left wins when both are near
        if (dashed_line && g == G_NONE)
        begin
            if (right_stat.near_round)
                g = G_ROUND_R;
            if (left_stat.near_round)
                g = G_ROUND_L;
        end

        if (command)
            comb_state = (forced_state > G_ROUND_L) ? G_ERROR : gstate_t'(forced_state);
        else
            comb_state = g;
    end

    assign overall_next  = en ? comb_state : overall_reg;
    assign global_state  = comb_state;
    assign state_changed = (comb_state != overall_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            overall_reg <= G_NONE;
        else
            overall_reg <= overall_next;
    end

endmodule
`default_nettype wire

[rtl/wall_type_classifier_core.sv]
// Top level of the wall type classifier: config registers, two side lanes, merge, output queue.
//
//  channel  direction  handshake      payload
//  sample   in         valid/ready    command, distances, odometer, dashed flag, forced state
//  result   out        valid/ready    global state, side states, change flag
//  cfg      in         cfg_we only    cfg_index, cfg_data
//
// One item per cycle while the queue has room: both side lanes and the merge work in
// the accept cycle, and the result is registered into a two-entry output queue that drives the result port.
// Input is stalled only when the queue holds two unread results.
// Reset initialises all side and global state, loads the register defaults, empties the queue.
`default_nettype none
module wall_type_classifier_core #(
    parameter int DIST_BITS = 10,
    parameter int POS_BITS  = 32,
    parameter int LEN_BITS  = 24
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    wtc_in_if.sink                                  sample,
    wtc_out_if.source                               result,
    input  wire logic                               cfg_we,
    input  wire logic [wtc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [wtc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import wtc_pkg::*;

    logic [THR_BITS-1:0]      wall_threshold_reg;
    logic [WLEN_CFG_BITS-1:0] min_wall_length_reg;
    logic [THR_BITS-1:0]      spread_limit_reg;
    logic [THR_BITS-1:0]      round_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_threshold_reg  <= WALL_THRESHOLD_RST;
            min_wall_length_reg <= MIN_WALL_LENGTH_RST;
            spread_limit_reg    <= SPREAD_LIMIT_RST;
            round_threshold_reg <= ROUND_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WALL_THRESHOLD:  wall_threshold_reg  <= cfg_data[THR_BITS-1:0];
                REG_MIN_WALL_LENGTH: min_wall_length_reg <= cfg_data[WLEN_CFG_BITS-1:0];
                REG_SPREAD_LIMIT:    spread_limit_reg    <= cfg_data[THR_BITS-1:0];
                REG_ROUND_THRESHOLD: round_threshold_reg <= cfg_data[THR_BITS-1:0];
                default:             ;
            endcase
        end
    end

    logic       push;
    logic       pop;
    logic       lane_en;
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    result_t    q_reg [2];
    result_t    res;

    side_stat_t right_stat;
    side_stat_t left_stat;
    gstate_t    g_state;
    logic       g_changed;

    assign sample.ready = (count_reg != 2'd2);
    assign push         = sample.valid && sample.ready;
    assign pop          = result.valid && result.ready;
    assign lane_en      = push && !sample.command;

    wtc_side #(
        .DIST_BITS (DIST_BITS),
        .POS_BITS  (POS_BITS),
        .LEN_BITS  (LEN_BITS)
    ) u_right (
        .clk                  (clk),
        .rst_n                (rst_n),
        .en                   (lane_en),
        .distance             (sample.right_distance),
        .position             (sample.odometer_position),
        .wall_threshold       (wall_threshold_reg),
        .min_wall_length      (min_wall_length_reg),
        .spread_limit         (spread_limit_reg),
        .roundabout_threshold (round_threshold_reg),
        .stat                 (right_stat)
    );

    wtc_side #(
        .DIST_BITS (DIST_BITS),
        .POS_BITS  (POS_BITS),
        .LEN_BITS  (LEN_BITS)
    ) u_left (
        .clk                  (clk),
        .rst_n                (rst_n),
        .en                   (lane_en),
        .distance             (sample.left_distance),
        .position             (sample.odometer_position),
        .wall_threshold       (wall_threshold_reg),
        .min_wall_length      (min_wall_length_reg),
        .spread_limit         (spread_limit_reg),
        .roundabout_threshold (round_threshold_reg),
        .stat                 (left_stat)
    );

    wtc_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (push),
        .command       (sample.command),
        .forced_state  (sample.forced_state),
        .dashed_line   (sample.dashed_line),
        .right_stat    (right_stat),
        .left_stat     (left_stat),
        .global_state  (g_state),
        .state_changed (g_changed)
    );

    assign res.global_state     = g_state;
    assign res.right_side_state = right_stat.cls;
    assign res.left_side_state  = left_stat.cls;
    assign res.state_changed    = g_changed;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= res;
    end

    assign result.valid            = (count_reg != 2'd0);
    assign result.global_state     = q_reg[rd_ptr_reg].global_state;
    assign result.right_side_state = q_reg[rd_ptr_reg].right_side_state;
    assign result.left_side_state  = q_reg[rd_ptr_reg].left_side_state;
    assign result.state_changed    = q_reg[rd_ptr_reg].state_changed;

endmodule
`default_nettype wire

[sim/tb_wall_type_classifier_core.sv]
// Self-checking testbench of the wall type classifier core: directed rows, random walls, stalls.
module tb_wall_type_classifier_core;
    timeunit 1ns;
    timeprecision 1ps;

    import wtc_pkg::*;

    localparam longint RUN_MAX = 64'sd8388607;
    localparam longint RUN_MIN = -64'sd8388608;
    localparam int ITEMS_PER_PHASE = 365;
    localparam int PHASES = 5;

    typedef struct packed {
        logic        cmd;
        logic [9:0]  rd;
        logic [9:0]  ld;
        logic [31:0] pos;
        logic        dashed;
        logic [3:0]  forced;
    } tick_t;

    typedef struct packed {
        gstate_t gs;
        cls_t    rs;
        cls_t    ls;
        logic    chg;
    } report_t;

    typedef struct packed {
        logic    typed;
        tick_t   stim;
        report_t want;
    } row_t;

    typedef struct {
        cls_t        cls;
        logic [9:0]  lo;
        logic [9:0]  hi;
        logic [31:0] mark;
        longint      run;
    } wall_track_t;

    localparam report_t UNTYPED = '{G_NONE, CLS_NONE, CLS_NONE, 1'b0};

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    wtc_in_if #(.DIST_BITS(10), .POS_BITS(32)) sample_ch ();
    wtc_out_if result_ch ();

    wall_type_classifier_core #(
        .DIST_BITS(10),
        .POS_BITS (32),
        .LEN_BITS (24)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (sample_ch),
        .result   (result_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state and its copy of the registers
    logic [9:0]  wall_thr;
    logic [15:0] wall_len_min;
    logic [9:0]  smooth_spread;
    logic [9:0]  round_thr;
    wall_track_t right_wall;
    wall_track_t left_wall;
    gstate_t     road_state;

    report_t pending_states [$];
    int      fail_count;

    // Stimulus shaping
    int          hold_request;
    int          no_gap_left;
    bit          send_idle_on;
    int          burst_left;
    logic [31:0] odo;
    bit          in_wall [2];
    int          span_left [2];
    int          wall_base [2];
    int          wall_amp [2];

    row_t directed_rows [25];

    function automatic void track_side(inout wall_track_t s, input logic [9:0] d,
                                       input logic [31:0] pos);
        logic [31:0] delta;
        longint      acc;
        if (d > wall_thr)
            s.cls = CLS_NONE;
        else if (d < wall_thr)
        begin
            if (s.cls == CLS_NONE)
            begin
                s.lo   = d;
                s.hi   = d;
                s.mark = pos;
                s.run  = 0;
                s.cls  = CLS_MEAS;
            end
            else if (s.cls == CLS_MEAS)
            begin
                if (d < s.lo)
                    s.lo = d;
                if (d > s.hi)
                    s.hi = d;
                delta = pos - s.mark;
                acc   = s.run + longint'($signed(delta));
                if (acc > RUN_MAX)
                    acc = RUN_MAX;
                if (acc < RUN_MIN)
                    acc = RUN_MIN;
                s.run  = acc;
                s.mark = pos;
                if (s.run > longint'(wall_len_min))
                    s.cls = ((int'(s.hi) - int'(s.lo)) < int'(smooth_spread)) ?
                            CLS_SMOOTH : CLS_RIBBED;
            end
        end
    endfunction

    function automatic void merge_sides();
        cls_t l;
        l = left_wall.cls;
        case (right_wall.cls)
            CLS_NONE:
            begin
                if (l == CLS_NONE)
                    road_state = G_NONE;
                else if (l == CLS_SMOOTH && road_state != G_GATE)
                    road_state = G_SMOOTH_L;
                else if (l == CLS_RIBBED)
                    road_state = G_RIBBED_L;
            end
            CLS_SMOOTH:
            begin
                if (l == CLS_NONE && road_state != G_GATE)
                    road_state = G_SMOOTH_R;
                else if (l == CLS_SMOOTH)
                    road_state = G_GATE;
                else if (l == CLS_RIBBED)
                    road_state = G_ERROR;
            end
            CLS_RIBBED:
                road_state = (l == CLS_NONE) ? G_RIBBED_R : G_ERROR;
            default:
                ; // right side still measuring: global state holds
        endcase
    endfunction

    function automatic report_t predict_wall_state(tick_t t);
        gstate_t was;
        report_t r;
        was = road_state;
        if (t.cmd)
            road_state = (t.forced > G_ROUND_L) ? G_ERROR : gstate_t'(t.forced);
        else
        begin
            track_side(right_wall, t.rd, t.pos);
            track_side(left_wall, t.ld, t.pos);
            merge_sides();
            if (t.dashed && road_state == G_NONE)
            begin
                if (t.rd < round_thr)
                    road_state = G_ROUND_R;
                if (t.ld < round_thr)
                    road_state = G_ROUND_L;
            end
        end
        r.gs  = road_state;
        r.rs  = right_wall.cls;
        r.ls  = left_wall.cls;
        r.chg = (road_state != was);
        return r;
    endfunction

    function automatic void reset_prediction();
        wall_thr        = WALL_THRESHOLD_RST;
        wall_len_min    = MIN_WALL_LENGTH_RST;
        smooth_spread   = SPREAD_LIMIT_RST;
        round_thr       = ROUND_THRESHOLD_RST;
        right_wall.cls  = CLS_NONE;
        right_wall.lo   = 10'(SIDE_MIN_RST);
        right_wall.hi   = '0;
        right_wall.mark = '0;
        right_wall.run  = 0;
        left_wall       = right_wall;
        road_state      = G_NONE;
    endfunction

    task automatic cfg_write(input cfg_reg_t r, input logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        case (r)
            REG_WALL_THRESHOLD:  wall_thr      = v[9:0];
            REG_MIN_WALL_LENGTH: wall_len_min  = v;
            REG_SPREAD_LIMIT:    smooth_spread = v[9:0];
            REG_ROUND_THRESHOLD: round_thr     = v[9:0];
            default:             ;
        endcase
        @(posedge clk);
    endtask

    task automatic settle_all();
        while (pending_states.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Holds the item on the port until taken, then books its expected result
    task automatic offer(input tick_t t, input logic typed, input report_t want);
        report_t predicted;
        sample_ch.valid             <= 1'b1;
        sample_ch.command           <= t.cmd;
        sample_ch.right_distance    <= t.rd;
        sample_ch.left_distance     <= t.ld;
        sample_ch.odometer_position <= t.pos;
        sample_ch.dashed_line       <= t.dashed;
        sample_ch.forced_state      <= t.forced;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        predicted = predict_wall_state(t);
        pending_states.push_back(typed ? want : predicted);
    endtask

    task automatic sender_gap();
        int r;
        int g;
        g = 0;
        if (burst_left == 0)
        begin
            send_idle_on = !send_idle_on;
            burst_left   = $urandom_range(30, 120);
        end
        burst_left--;
        if (no_gap_left > 0)
            no_gap_left--;
        else if (send_idle_on)
        begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                g = $urandom_range(8, 30);
            else if (r >= 70)
                g = $urandom_range(1, 3);
        end
        if (g > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Runs of wall / open space per side so that walls live long enough to classify
    function automatic logic [9:0] pick_reading(int i);
        int thr;
        int v;
        int r;
        thr = int'(wall_thr);
        if (span_left[i] == 0)
        begin
            in_wall[i]   = ($urandom_range(0, 99) < 60);
            span_left[i] = $urandom_range(2, 25);
            wall_base[i] = (thr == 0) ? 0 : $urandom_range(0, thr - 1);
            wall_amp[i]  = $urandom_range(0, 1) ? $urandom_range(0, int'(smooth_spread)) :
                           $urandom_range(int'(smooth_spread), 2 * int'(smooth_spread) + 8);
        end
        span_left[i]--;
        r = $urandom_range(0, 99);
        if (r < 4)
            v = thr;
        else if (in_wall[i])
        begin
            v = wall_base[i] + $urandom_range(0, wall_amp[i]);
            if (thr > 0 && v >= thr)
                v = thr - 1;
        end
        else if (thr >= 1023)
            v = 1023;
        else if (r < 45)
            v = $urandom_range(thr + 1, (thr + 64 > 1023) ? 1023 : thr + 64);
        else
            v = $urandom_range(thr + 1, 1023);
        if (v > 1023)
            v = 1023;
        return 10'(v);
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        int    r;
        r = $urandom_range(0, 99);
        t.cmd    = 1'b0;
        t.rd     = 10'($urandom());
        t.ld     = 10'($urandom());
        t.pos    = $urandom();
        t.dashed = 1'($urandom());
        t.forced = 4'($urandom());
        if (r < 8)
            t.cmd = 1'($urandom());
        else if (r < 14)
            t.cmd = 1'b1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                odo = $urandom();
            else if (r < 6)
                odo = odo - $urandom_range(0, 2000);
            else
                odo = odo + $urandom_range(0, int'(wall_len_min) / 4 + 16);
            t.rd     = pick_reading(0);
            t.ld     = pick_reading(1);
            t.pos    = odo;
            t.dashed = ($urandom_range(0, 99) < 30);
        end
        return t;
    endfunction

    // Result checker
    always @(posedge clk)
    begin : check_results
        report_t got;
        report_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.gs  = gstate_t'(result_ch.global_state);
            got.rs  = cls_t'(result_ch.right_side_state);
            got.ls  = cls_t'(result_ch.left_side_state);
            got.chg = result_ch.state_changed;
            if (pending_states.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: gs=%0d rs=%0d ls=%0d chg=%0b",
                             got.gs, got.rs, got.ls, got.chg);
            end
            else
            begin
                want = pending_states.pop_front();
                if (got.gs !== want.gs || got.rs !== want.rs || got.ls !== want.ls ||
                    got.chg !== want.chg)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected gs=%0d rs=%0d ls=%0d chg=%0b, got gs=%0d rs=%0d ls=%0d chg=%0b",
                                 want.gs, want.rs, want.ls, want.chg,
                                 got.gs, got.rs, got.ls, got.chg);
                end
            end
        end
    end

    // Result receiver: random stalls, calm stretches and a long hold-off on request
    initial
    begin : result_sink
        int  r;
        int  hold;
        int  mode_left;
        bit  idle_on;
        result_ch.ready <= 1'b0;
        idle_on   = 1'b1;
        mode_left = 100;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                idle_on   = !idle_on;
                mode_left = $urandom_range(50, 200);
            end
            mode_left--;
            if (hold_request > 0)
            begin
                hold         = hold_request;
                hold_request = 0;
                result_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            else if (!idle_on)
                result_ch.ready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    result_ch.ready <= 1'b1;
                else if (r < 96)
                    result_ch.ready <= 1'b0;
                else
                begin
                    result_ch.ready <= 1'b0;
                    repeat ($urandom_range(8, 30)) @(posedge clk);
                end
            end
        end
    end

    // Watchdog: reports a fail and ends the run if the test has not finished before this timeout
    initial
    begin
        #5000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        tick_t t;
        rst_n                       <= 1'b0;
        cfg_we                      <= 1'b0;
        cfg_index                   <= REG_WALL_THRESHOLD;
        cfg_data                    <= '0;
        sample_ch.valid             <= 1'b0;
        sample_ch.command           <= 1'b0;
        sample_ch.right_distance    <= '0;
        sample_ch.left_distance     <= '0;
        sample_ch.odometer_position <= '0;
        sample_ch.dashed_line       <= 1'b0;
        sample_ch.forced_state      <= '0;
        fail_count   = 0;
        hold_request = 0;
        no_gap_left  = 0;
        send_idle_on = 1'b1;
        burst_left   = 60;
        odo          = '0;
        for (int i = 0; i < 2; i++)
            span_left[i] = 0;
        reset_prediction();

        // typed | cmd rd ld pos dashed forced | expected where obvious
        directed_rows = '{
            '{1'b1, '{1'b0, 10'd1023, 10'd1023, 32'h0, 1'b0, 4'd0},
              '{G_NONE, CLS_NONE, CLS_NONE, 1'b0}},
            '{1'b1, '{1'b1, 10'd0, 10'd0, 32'h0, 1'b0, 4'd15},
              '{G_ERROR, CLS_NONE, CLS_NONE, 1'b1}},
            '{1'b1, '{1'b1, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 1'b1, 4'd8},
              '{G_ROUND_L, CLS_NONE, CLS_NONE, 1'b1}},
            '{1'b1, '{1'b1, 10'd0, 10'd0, 32'h0, 1'b0, 4'd0},
              '{G_NONE, CLS_NONE, CLS_NONE, 1'b1}},
            // readings on the threshold, dashed line, both below roundabout level
            '{1'b0, '{1'b0, 10'd144, 10'd144, 32'h0, 1'b1, 4'd0}, UNTYPED},
            // right wall across the position wrap, then smooth
            '{1'b0, '{1'b0, 10'd100, 10'd1023, 32'h7FFF_FF00, 1'b0, 4'd0}, UNTYPED},
            '{1'b0, '{1'b0, 10'd110, 10'd1023, 32'h7FFF_FFF0, 1'b0, 4'd0}, UNTYPED},
            '{1'b0, '{1'b0, 10'd144, 10'd1023, 32'h7FFF_FFF8, 1'b0, 4'd0}, UNTYPED},
            '{1'b0, '{1'b0, 10'd105, 10'd1023, 32'h8000_0060, 1'b0, 4'd0}, UNTYPED},
            '{1'b0, '{1'b0, 10'd0, 10'd1023, 32'h8000_0070, 1'b0, 4'd0}, UNTYPED},
            // left goes ribbed against a smooth right
            '{1'b0, '{1'b0, 10'd0, 10'd50, 32'h8000_0080, 1'b0, 4'd0}, UNTYPED},
            '{1'b0, '{1'b0, 10'd0, 10'd0, 32'h8000_0400, 1'b0, 4'd0}, UNTYPED},
            '{1'b0, '{1'b0, 10'd1023, 10'd0, 32'h8000_0410, 1'b0, 4'd0}, UNTYPED},
            '{1'b0, '{1'b0, 10'd1023, 10'd1023, 32'h8000_0420, 1'b0, 4'd0}, UNTYPED},
            // gate, then gate held by one smooth side
            '{1'b0, '{1'b0, 10'd10, 10'd10, 32'h0, 1'b0, 4'd0}, UNTYPED},
            '{1'b0, '{1'b0, 10'd10, 10'd10, 32'd400, 1'b0, 4'd0}, UNTYPED},
            '{1'b0, '{1'b0, 10'd1023, 10'd10, 32'd500, 1'b0, 4'd0}, UNTYPED},
            '{1'b0, '{1'b0, 10'd1023, 10'd1023, 32'd600, 1'b0, 4'd0}, UNTYPED},
            // length saturates upward
            '{1'b0, '{1'b0, 10'd0, 10'd1023, 32'h0, 1'b0, 4'd0}, UNTYPED},
            '{1'b0, '{1'b0, 10'd0, 10'd1023, 32'h7FFF_FFFF, 1'b0, 4'd0}, UNTYPED},
            '{1'b0, '{1'b0, 10'd1023, 10'd1023, 32'h0, 1'b0, 4'd0}, UNTYPED},
            // travel backwards down to the lower bound
            '{1'b0, '{1'b0, 10'd5, 10'd1023, 32'd1000, 1'b0, 4'd0}, UNTYPED},
            '{1'b0, '{1'b0, 10'd5, 10'd1023, 32'h0, 1'b0, 4'd0}, UNTYPED},
            '{1'b0, '{1'b0, 10'd5, 10'd1023, 32'h8000_0000, 1'b0, 4'd0}, UNTYPED},
            '{1'b0, '{1'b0, 10'd143, 10'd143, 32'h0, 1'b1, 4'd0}, UNTYPED}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            offer(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
            sender_gap();
        end

        for (int p = 0; p < PHASES; p++)
        begin
            sample_ch.valid <= 1'b0;
            settle_all();
            case (p)
                1:
                begin
                    // every data bit set; 10-bit registers keep the low bits
                    cfg_write(REG_WALL_THRESHOLD, 16'hFFFF);
                    cfg_write(REG_MIN_WALL_LENGTH, 16'hFFFF);
                    cfg_write(REG_SPREAD_LIMIT, 16'hFFFF);
                    cfg_write(REG_ROUND_THRESHOLD, 16'hFFFF);
                end
                2:
                begin
                    cfg_write(REG_WALL_THRESHOLD, 16'd0);
                    cfg_write(REG_MIN_WALL_LENGTH, 16'd0);
                    cfg_write(REG_SPREAD_LIMIT, 16'd0);
                    cfg_write(REG_ROUND_THRESHOLD, 16'd0);
                end
                3:
                begin
                    cfg_write(REG_WALL_THRESHOLD, 16'($urandom_range(60, 700)));
                    cfg_write(REG_MIN_WALL_LENGTH, 16'($urandom_range(0, 2000)));
                    cfg_write(REG_SPREAD_LIMIT, 16'($urandom_range(0, 200)));
                    cfg_write(REG_ROUND_THRESHOLD, 16'($urandom_range(0, 1023)));
                end
                4:
                begin
                    cfg_write(REG_WALL_THRESHOLD, 16'd200);
                    cfg_write(REG_MIN_WALL_LENGTH, 16'd100);
                    cfg_write(REG_SPREAD_LIMIT, 16'd16);
                    cfg_write(REG_ROUND_THRESHOLD, 16'd300);
                end
                default:
                    ;
            endcase
            cfg_we <= 1'b0;
            for (int i = 0; i < 2; i++)
                span_left[i] = 0;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (p == 0 && n == 120)
                begin
                    // receiver holds off while items keep coming: queue fills, input stalls
                    hold_request = 80;
                    no_gap_left  = 40;
                end
                if (p == 2 && n == 150)
                begin
                    sample_ch.valid <= 1'b0;
                    settle_all();
                end
                t = random_tick();
                offer(t, 1'b0, UNTYPED);
                sender_gap();
            end
        end

        sample_ch.valid <= 1'b0;
        settle_all();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
rtl/wtc_pkg.sv
rtl/wtc_if.sv
rtl/wtc_side.sv
rtl/wtc_merge.sv
rtl/wall_type_classifier_core.sv
sim/tb_wall_type_classifier_core.sv
